>>> rtl/assert_macros.svh
// assertion macros for the grouped attention mask rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside of reset
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

>>> rtl/tgam_pkg.sv
// package with types, constants and functions of the grouped attention mask
package tgam_pkg;

    localparam int DIV_BITS = 12;
    localparam int POS_W = 12;
    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] MAX_TOKENS = 13'd4096;

    typedef enum logic [2:0]
    {
        REG_CONTEXT_LENGTH    = 3'd0,
        REG_HISTORY_END       = 3'd1,
        REG_CAUSAL_MODE       = 3'd2,
        REG_CONTEXT_MASK_OFF  = 3'd3,
        REG_TARGET_GROUP_SIZE = 3'd4
    } tgam_reg_t;

    // collapsed positions and flags after the first stage
    typedef struct packed
    {
        logic [POS_W-1:0] rpos;
        logic [POS_W-1:0] cpos;
        logic [CFG_W-1:0] hend;
        logic             diag;
        logic             ctx_nz;
        logic             causal;
        logic [CFG_W-1:0] gsize;
    } tgam_s1_t;

    // group index division state, two dividers side by side
    typedef struct packed
    {
        logic [DIV_BITS-1:0] a;
        logic [DIV_BITS-1:0] b;
        logic [DIV_BITS-1:0] rem_a;
        logic [DIV_BITS-1:0] rem_b;
        logic [DIV_BITS-1:0] q_a;
        logic [DIV_BITS-1:0] q_b;
        logic [CFG_W-1:0]    gsize;
        logic                ok_dist;
        logic                r_tgt;
        logic                c_tgt;
        logic                over;
    } tgam_div_t;

    typedef struct packed
    {
        logic                q;
        logic [DIV_BITS-1:0] rem;
    } tgam_step_t;

    // one restoring division step, remainder stays below the divisor
    function automatic tgam_step_t div_step(logic [DIV_BITS-1:0] rem, logic bit_in,
                                            logic [CFG_W-1:0] d);
        logic [DIV_BITS:0] t;
        logic [DIV_BITS:0] diff;
        tgam_step_t res;
        t = {rem, bit_in};
        diff = t - d;
        if (t >= d)
        begin
            res.q = 1'b1;
            res.rem = diff[DIV_BITS-1:0];
        end
        else
        begin
            res.q = 1'b0;
            res.rem = t[DIV_BITS-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/target_grouped_attention_mask.sv
// grouped attention mask: one permission bit per query row and key column transfer
// throughput: one transfer per cycle while out_ready takes the results, set by the 12-stage pipelined group divider
// each stage holds its item while its successor is full, so bubbles fill up on a stall
// reset: rst_n async low clears all valid bits and loads the register reset values
`include "assert_macros.svh"

module target_grouped_attention_mask
    import tgam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // apb-style configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [POS_W-1:0]  query_row,
    input  logic [POS_W-1:0]  key_column,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              allowed
);

    localparam int NDV = DIV_BITS + 1;

    // configuration registers
    logic [CFG_W-1:0] ctx_len_reg;
    logic [CFG_W-1:0] hist_end_reg;
    logic             causal_reg;
    logic             ctx_off_reg;
    logic [CFG_W-1:0] gsize_reg;

    logic             cfg_wr;
    tgam_reg_t        cfg_sel;
    logic [CFG_W-1:0] wr_sat;

    // pipeline stages
    logic             s1_valid_reg;
    tgam_s1_t         s1_reg;
    tgam_s1_t         s1_next;
    logic             s1_rdy;

    // index 0 is the compare stage, 1..DIV_BITS are the divider steps
    logic             dv_valid_reg [NDV];
    tgam_div_t        dv_reg [NDV];
    tgam_div_t        dv_next [NDV];
    logic             dv_rdy [NDV];

    logic             out_valid_reg;
    logic             allowed_reg;
    logic             allowed_next;
    logic             out_rdy;

    logic [CFG_W-1:0] ctx;
    logic [CFG_W-1:0] gsize_eff;

    // ---------------------------------------------------------------
    // configuration port, written in the access phase
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign cfg_sel = tgam_reg_t'(paddr[4:2]);
    // writes keep 13 bits and saturate to the token limit
    assign wr_sat = (pwdata[CFG_W-1:0] > MAX_TOKENS) ? MAX_TOKENS : pwdata[CFG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_len_reg  <= '0;
            hist_end_reg <= '0;
            causal_reg   <= 1'b1;
            ctx_off_reg  <= 1'b0;
            gsize_reg    <= CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_CONTEXT_LENGTH:    ctx_len_reg  <= wr_sat;
                REG_HISTORY_END:       hist_end_reg <= wr_sat;
                REG_CAUSAL_MODE:       causal_reg   <= pwdata[0];
                REG_CONTEXT_MASK_OFF:  ctx_off_reg  <= pwdata[0];
                REG_TARGET_GROUP_SIZE: gsize_reg    <= wr_sat;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_CONTEXT_LENGTH:    prdata = {{(32-CFG_W){1'b0}}, ctx_len_reg};
            REG_HISTORY_END:       prdata = {{(32-CFG_W){1'b0}}, hist_end_reg};
            REG_CAUSAL_MODE:       prdata = {31'd0, causal_reg};
            REG_CONTEXT_MASK_OFF:  prdata = {31'd0, ctx_off_reg};
            REG_TARGET_GROUP_SIZE: prdata = {{(32-CFG_W){1'b0}}, gsize_reg};
            default:               prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // backpressure: a stage takes new data when empty or draining
    // ---------------------------------------------------------------
    assign out_rdy = !out_valid_reg || out_ready;

    always_comb
    begin
        dv_rdy[NDV-1] = !dv_valid_reg[NDV-1] || out_rdy;
        for (int k = NDV - 2; k >= 0; k--)
        begin
            dv_rdy[k] = !dv_valid_reg[k] || dv_rdy[k+1];
        end
        s1_rdy = !s1_valid_reg || dv_rdy[0];
    end

    assign in_ready = s1_rdy;

    // ---------------------------------------------------------------
    // stage 1: collapse context tokens onto position zero
    // ---------------------------------------------------------------
    function automatic logic [CFG_W-1:0] collapse(logic [CFG_W-1:0] idx,
                                                  logic [CFG_W-1:0] c);
        logic [CFG_W-1:0] p;
        p = idx - c + CFG_W'(1);
        if (c == '0)
            return idx;
        else if (idx >= c)
            return p;
        else
            return '0;
    endfunction

    assign ctx = ctx_off_reg ? '0 : ctx_len_reg;
    // a group size of zero acts as one
    assign gsize_eff = (gsize_reg == '0) ? CFG_W'(1) : gsize_reg;

    always_comb
    begin
        logic [CFG_W-1:0] rp;
        logic [CFG_W-1:0] cp;
        rp = collapse({1'b0, query_row}, ctx);
        cp = collapse({1'b0, key_column}, ctx);
        s1_next.rpos   = rp[POS_W-1:0];
        s1_next.cpos   = cp[POS_W-1:0];
        s1_next.hend   = collapse(hist_end_reg, ctx);
        s1_next.diag   = (query_row == key_column);
        s1_next.ctx_nz = (ctx != '0);
        s1_next.causal = causal_reg;
        s1_next.gsize  = gsize_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_rdy)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
            s1_reg <= s1_next;
    end

    // ---------------------------------------------------------------
    // stage 2: ordering test, target flags, offsets into the target run
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [CFG_W-1:0] da;
        logic [CFG_W-1:0] db;
        da = {1'b0, s1_reg.rpos} - s1_reg.hend;
        db = {1'b0, s1_reg.cpos} - s1_reg.hend;
        dv_next[0].a       = da[DIV_BITS-1:0];
        dv_next[0].b       = db[DIV_BITS-1:0];
        dv_next[0].rem_a   = '0;
        dv_next[0].rem_b   = '0;
        dv_next[0].q_a     = '0;
        dv_next[0].q_b     = '0;
        dv_next[0].gsize   = s1_reg.gsize;
        // causal needs the row after the column, symmetric needs them apart
        dv_next[0].ok_dist = s1_reg.diag ||
                             (s1_reg.causal ? (s1_reg.rpos > s1_reg.cpos)
                                            : (s1_reg.rpos != s1_reg.cpos));
        dv_next[0].r_tgt   = ({1'b0, s1_reg.rpos} >= s1_reg.hend);
        dv_next[0].c_tgt   = ({1'b0, s1_reg.cpos} >= s1_reg.hend);
        // collapsed first row sees the whole history
        dv_next[0].over    = s1_reg.ctx_nz && (s1_reg.rpos == '0) &&
                             ({1'b0, s1_reg.cpos} < s1_reg.hend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (dv_rdy[0])
            dv_valid_reg[0] <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (dv_rdy[0] && s1_valid_reg)
            dv_reg[0] <= dv_next[0];
    end

    // ---------------------------------------------------------------
    // stages 3..14: group index of row and column, one quotient bit each
    // ---------------------------------------------------------------
    for (genvar k = 1; k < NDV; k++)
    begin : g_div
        always_comb
        begin
            tgam_step_t sa;
            tgam_step_t sb;
            sa = div_step(dv_reg[k-1].rem_a, dv_reg[k-1].a[DIV_BITS-k], dv_reg[k-1].gsize);
            sb = div_step(dv_reg[k-1].rem_b, dv_reg[k-1].b[DIV_BITS-k], dv_reg[k-1].gsize);
            dv_next[k]       = dv_reg[k-1];
            dv_next[k].rem_a = sa.rem;
            dv_next[k].rem_b = sb.rem;
            dv_next[k].q_a   = {dv_reg[k-1].q_a[DIV_BITS-2:0], sa.q};
            dv_next[k].q_b   = {dv_reg[k-1].q_b[DIV_BITS-2:0], sb.q};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k] <= 1'b0;
            else if (dv_rdy[k])
                dv_valid_reg[k] <= dv_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (dv_rdy[k] && dv_valid_reg[k-1])
                dv_reg[k] <= dv_next[k];
        end
    end

    // ---------------------------------------------------------------
    // stage 15: group match and final decision, output register
    // ---------------------------------------------------------------
    assign allowed_next = dv_reg[NDV-1].over ||
                          (dv_reg[NDV-1].ok_dist &&
                           ((dv_reg[NDV-1].q_a == dv_reg[NDV-1].q_b) ||
                            !dv_reg[NDV-1].r_tgt || !dv_reg[NDV-1].c_tgt));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_rdy)
            out_valid_reg <= dv_valid_reg[NDV-1];
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && dv_valid_reg[NDV-1])
            allowed_reg <= allowed_next;
    end

    assign out_valid = out_valid_reg;
    assign allowed   = allowed_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ASSERT_CLK(a_cfg_sat, (ctx_len_reg <= MAX_TOKENS) && (hist_end_reg <= MAX_TOKENS) &&
        (gsize_reg <= MAX_TOKENS), "configuration register above token limit")

    `ASSERT_IMPL(a_in_stall, in_valid && !in_ready, s1_valid_reg && !dv_rdy[0],
        "input stalled while the first stage can move")

    `ASSERT_IMPL(a_div_rem, dv_valid_reg[NDV-1],
        (dv_reg[NDV-1].rem_a < dv_reg[NDV-1].gsize) &&
        (dv_reg[NDV-1].rem_b < dv_reg[NDV-1].gsize),
        "divider remainder not below group size")

    `ASSERT_IMPL(a_out_fill, out_valid_reg && out_ready && dv_valid_reg[NDV-1],
        ##1 out_valid_reg, "pipeline result lost at the output stage")

endmodule

>>> bench/grouped_mask_checker.sv
`timescale 1ns / 100ps
// checker that mirrors the mask registers, predicts every permission bit and compares results
module grouped_mask_checker
    import tgam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [POS_W-1:0] query_row,
    input  logic [POS_W-1:0] key_column,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             allowed,
    output int               mismatch_count,
    output int               pending_count
);

    localparam int MAX_PRINTED = 100;

    typedef struct
    {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             grant;
    } grant_t;

    grant_t grant_q[$];
    grant_t oldest;
    grant_t fresh;

    // register mirror
    int   ctx_len;
    int   hist_end;
    int   gsize_mirror;
    logic causal;
    logic ctx_off;

    function automatic int clamp_tokens(input logic [31:0] value);
        int t;
        t = int'(value[CFG_W-1:0]);
        return (t > int'(MAX_TOKENS)) ? int'(MAX_TOKENS) : t;
    endfunction

    // context tokens fold onto position zero
    function automatic int fold_context(input int idx, input int ctx);
        int p;
        if (ctx <= 0)
            return idx;
        p = idx - ctx + 1;
        return (p > 0) ? p : 0;
    endfunction

    function automatic int target_group(input int pos, input int hend, input int gsize);
        if (pos < hend)
            return -1;
        return (pos - hend) / gsize;
    endfunction

    function automatic logic predict_grant(input logic [POS_W-1:0] row,
                                           input logic [POS_W-1:0] col);
        int   ctx;
        int   gsize;
        int   rpos;
        int   cpos;
        int   hend;
        int   delta;
        int   rg;
        int   cg;
        logic ok;
        ctx = ctx_off ? 0 : ctx_len;
        gsize = (gsize_mirror == 0) ? 1 : gsize_mirror;
        rpos = fold_context(int'(row), ctx);
        cpos = fold_context(int'(col), ctx);
        hend = fold_context(hist_end, ctx);
        delta = rpos - cpos;
        if (!causal && delta < 0)
            delta = -delta;
        ok = (row == col) || (delta > 0);
        rg = target_group(rpos, hend, gsize);
        cg = target_group(cpos, hend, gsize);
        ok = ok && (rg == cg || rg < 0 || cg < 0);
        // folded first row sees the whole history
        if (ctx > 0 && rpos == 0 && cpos < hend)
            ok = 1'b1;
        return ok;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("checker: %s", msg);
        mismatch_count++;
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_CONTEXT_LENGTH:    ctx_len = clamp_tokens(data);
            REG_HISTORY_END:       hist_end = clamp_tokens(data);
            REG_CAUSAL_MODE:       causal = data[0];
            REG_CONTEXT_MASK_OFF:  ctx_off = data[0];
            REG_TARGET_GROUP_SIZE: gsize_mirror = clamp_tokens(data);
            default:               ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_len = 0;
            hist_end = 0;
            causal = 1'b1;
            ctx_off = 1'b0;
            gsize_mirror = 1;
            grant_q.delete();
            mismatch_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (grant_q.size() == 0)
                    report_mismatch($sformatf("unexpected transfer, allowed %0b", allowed));
                else
                begin
                    oldest = grant_q.pop_front();
                    if (allowed !== oldest.grant)
                        report_mismatch($sformatf("row %0d col %0d: allowed %0b, expected %0b",
                            oldest.row, oldest.col, allowed, oldest.grant));
                end
            end
            if (in_valid && in_ready)
            begin
                fresh.row = query_row;
                fresh.col = key_column;
                fresh.grant = predict_grant(query_row, key_column);
                grant_q = {grant_q, fresh};
            end
            // register writes take effect after this edge's prediction
            if (psel && penable && pwrite && pready)
                apply_write(paddr[4:2], pwdata);
            pending_count <= grant_q.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// top of the grouped attention mask bench: clock, reset, stimulus, watchdog and verdict
module testbench
    import tgam_pkg::*;
();

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRESSURE_PHASE  = 3;
    localparam int MAX_GAP         = 13;
    localparam int HOLD_CYCLES     = 300;
    // slowest correct stretch without a transfer is the long hold, well below this
    localparam int STALL_LIMIT     = 3000;
    // idle wait after the last result before the verdict
    localparam int DRAIN_CYCLES    = 30;
    localparam int LAST_POS        = (1 << POS_W) - 1;
    localparam int CFG_ALL         = (1 << CFG_W) - 1;
    localparam logic [2:0] FIRST_UNUSED_REG = 3'd5;
    localparam logic [2:0] LAST_UNUSED_REG  = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [4:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             in_valid;
    logic             in_ready;
    logic [POS_W-1:0] query_row;
    logic [POS_W-1:0] key_column;
    logic             out_valid;
    logic             out_ready;
    logic             allowed;

    int mismatch_count;
    int pending_count;
    int stall_cycles;

    // stimulus steering: gap and hold control shared by sender and receiver, anchors for the positions
    bit no_idle;
    bit hold_request;
    int ctx_anchor;
    int hend_anchor;
    int gsize_anchor;

    target_grouped_attention_mask i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .query_row  (query_row),
        .key_column (key_column),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .allowed    (allowed)
    );

    grouped_mask_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .query_row      (query_row),
        .key_column     (key_column),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .allowed        (allowed),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial clk = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    // random upper bits on top of a register value, the block keeps only the low bits
    function automatic logic [31:0] with_noise(input int value, input int width);
        logic [31:0] mask;
        logic [31:0] word;
        mask = (32'd1 << width) - 32'd1;
        word = $urandom();
        return (word & ~mask) | (value & mask);
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // token counts: zero, one, the maximum, oversized values, small groups and any position
    function automatic int pick_token_value();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return int'(MAX_TOKENS);
            3:       return int'($urandom_range(int'(MAX_TOKENS) + 1, CFG_ALL));
            4:       return int'($urandom_range(2, 64));
            default: return int'($urandom_range(0, LAST_POS));
        endcase
    endfunction

    // positions: uniform, around the context end, history end and group borders, low and top values
    function automatic logic [POS_W-1:0] pick_position();
        int p;
        case ($urandom_range(0, 5))
            0:       p = int'($urandom_range(0, LAST_POS));
            1:       p = ctx_anchor + int'($urandom_range(0, 6)) - 3;
            2:       p = hend_anchor + int'($urandom_range(0, 6)) - 3;
            3:       p = hend_anchor + gsize_anchor * int'($urandom_range(0, 3))
                         + int'($urandom_range(0, 2)) - 1;
            4:       p = int'($urandom_range(0, 15));
            default: p = LAST_POS - int'($urandom_range(0, 3));
        endcase
        if (p < 0)
            p = 0;
        if (p > LAST_POS)
            p = LAST_POS;
        return p[POS_W-1:0];
    endfunction

    // setup phase, access phase, then the port goes idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input int ctx, input int hend, input int causal,
                                input int mask_off, input int gsize);
        write_reg(REG_CONTEXT_LENGTH, with_noise(ctx, CFG_W));
        write_reg(REG_HISTORY_END, with_noise(hend, CFG_W));
        write_reg(REG_CAUSAL_MODE, with_noise(causal, 1));
        write_reg(REG_CONTEXT_MASK_OFF, with_noise(mask_off, 1));
        write_reg(REG_TARGET_GROUP_SIZE, with_noise(gsize, CFG_W));
        ctx_anchor = (ctx > int'(MAX_TOKENS)) ? int'(MAX_TOKENS) : ctx;
        hend_anchor = (hend > int'(MAX_TOKENS)) ? int'(MAX_TOKENS) : hend;
        gsize_anchor = (gsize > int'(MAX_TOKENS)) ? int'(MAX_TOKENS) : ((gsize < 1) ? 1 : gsize);
    endtask

    // returns at the accepting edge, valid stays high for a back-to-back follower
    task automatic send_pair(input int row, input int col);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        query_row <= row[POS_W-1:0];
        key_column <= col[POS_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid and wait until every predicted bit has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // receiver: one wait per result, a single long hold when requested
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int row;
        int col;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        query_row <= '0;
        key_column <= '0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        ctx_anchor = 0;
        hend_anchor = 0;
        gsize_anchor = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: every token is a target in its own group, only the diagonal passes
        send_pair(0, 0);
        send_pair(LAST_POS, LAST_POS);
        send_pair(LAST_POS, 0);
        send_pair(0, LAST_POS);
        wait_drained();

        // context of 8 folds rows 0..7 onto zero, history ends at folded 13, groups of 4
        write_config(8, 20, 1, 0, 4);
        send_pair(3, 5);          // both in context, folded first row sees history
        send_pair(10, 3);         // history row after folded context
        send_pair(3, 10);         // folded first row sees a later history token
        send_pair(12, 15);        // causal order violated
        send_pair(21, 20);        // two targets in one group
        send_pair(24, 22);        // targets in different groups
        send_pair(25, 10);        // target sees history
        send_pair(20, 20);        // diagonal
        send_pair(LAST_POS, LAST_POS);
        wait_drained();

        // symmetric distance
        write_reg(REG_CAUSAL_MODE, with_noise(0, 1));
        send_pair(12, 15);
        send_pair(15, 12);
        send_pair(5, 3);
        wait_drained();

        // context masking disabled, no folding at all
        write_reg(REG_CONTEXT_MASK_OFF, with_noise(1, 1));
        send_pair(3, 5);
        send_pair(5, 3);
        send_pair(0, LAST_POS);
        wait_drained();

        // oversized context and history saturate, group size zero acts as one
        write_config(CFG_ALL, 5000, 1, 0, 0);
        send_pair(LAST_POS, 0);
        send_pair(0, LAST_POS);
        send_pair(100, 50);
        wait_drained();

        // oversized group size, and a write to an unused register that must change nothing
        write_config(0, 100, 0, 0, CFG_ALL);
        write_reg(FIRST_UNUSED_REG, $urandom());
        send_pair(200, LAST_POS);
        send_pair(LAST_POS, 200);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_config(pick_token_value(), pick_token_value(), int'($urandom_range(0, 1)),
                         int'($urandom_range(0, 3) == 0), pick_token_value());
            if ($urandom_range(0, 2) == 0)
                write_reg(3'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)), $urandom());
            no_idle = ($urandom_range(0, 3) == 0);
            // sender keeps offering while the receiver holds off, so the pipe fills up
            if (phase == PRESSURE_PHASE)
            begin
                no_idle = 1'b1;
                hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                row = int'(pick_position());
                col = ($urandom_range(0, 9) == 0) ? row : int'(pick_position());
                send_pair(row, col);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
